// File: src/mbet_pkg.sv
package mbet_pkg;

    localparam int MAX_ITER_DEF    = 34;
    localparam int COORD_WIDTH_DEF = 12;

    localparam int FRAC_BITS = 28;
    localparam int Q_W       = 32;
    localparam int PROD_W    = 64;
    localparam int UPD_W     = 38;
    localparam int REG_W     = 13;
    localparam int COUNT_W   = 6;
    localparam int CFG_IDX_W = 1;

    localparam logic [Q_W-1:0]    THREE_HALF_Q = 32'h1800_0000;
    localparam logic [Q_W-1:0]    ONE_HALF_Q   = 32'h0800_0000;
    localparam logic [PROD_W-1:0] ESCAPE_Q56   = 64'h0400_0000_0000_0000;
    localparam logic [Q_W-1:0]    Q_MAX        = 32'h7FFF_FFFF;
    localparam logic [Q_W-1:0]    Q_MIN        = 32'h8000_0000;

    localparam logic [REG_W-1:0] WIDTH_RESET  = 13'd800;
    localparam logic [REG_W-1:0] HEIGHT_RESET = 13'd600;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 1'b1;

    typedef enum logic [1:0] {
        MUL_RR,
        MUL_II,
        MUL_RI
    } mul_sel_t;

    typedef struct packed {
        logic     load;
        logic     div_step;
        logic     map;
        logic     mul_en;
        mul_sel_t mul_sel;
        logic     z_update;
    } cmd_t;

    typedef struct packed {
        logic escaped;
    } status_t;

    // saturate an update sum to the q4.28 range
    function automatic logic signed [Q_W-1:0] sat_q(input logic signed [UPD_W-1:0] v);
        logic fits;
        fits = (v[UPD_W-1:Q_W-1] == '0) || (v[UPD_W-1:Q_W-1] == '1);
        if (fits)
        begin
            return v[Q_W-1:0];
        end
        else if (v[UPD_W-1])
        begin
            return Q_MIN;
        end
        else
        begin
            return Q_MAX;
        end
    endfunction

endpackage

// File: src/mbet_divider.sv
module mbet_divider #(
    parameter int DIVIDEND_W = mbet_pkg::COORD_WIDTH_DEF + mbet_pkg::FRAC_BITS
) (
    input  logic                        clk,
    input  logic                        start,
    input  logic                        step,
    input  logic [DIVIDEND_W-1:0]       dividend,
    input  logic [mbet_pkg::REG_W-1:0]  divisor,
    output logic [DIVIDEND_W-1:0]       quotient
);

    logic [mbet_pkg::REG_W-1:0] rem_reg;
    logic [mbet_pkg::REG_W-1:0] rem_next;
    logic [mbet_pkg::REG_W-1:0] div_reg;
    logic [DIVIDEND_W-1:0]      quo_reg;
    logic [DIVIDEND_W-1:0]      quo_next;
    logic [mbet_pkg::REG_W:0]   trial;
    logic [mbet_pkg::REG_W:0]   trial_diff;
    logic                       fits;

    // restoring division, one quotient bit per step
    always_comb
    begin
        trial      = {rem_reg, quo_reg[DIVIDEND_W-1]};
        trial_diff = trial - {1'b0, div_reg};
        fits       = (trial >= {1'b0, div_reg});
        rem_next   = fits ? trial_diff[mbet_pkg::REG_W-1:0] : trial[mbet_pkg::REG_W-1:0];
        quo_next   = {quo_reg[DIVIDEND_W-2:0], fits};
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            div_reg <= (divisor == '0) ? mbet_pkg::REG_W'(1) : divisor;
        end
        else if (step)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign quotient = quo_reg;

endmodule

// File: src/mbet_datapath.sv
module mbet_datapath #(
    parameter int COORD_WIDTH = mbet_pkg::COORD_WIDTH_DEF
) (
    input  logic                       clk,
    input  mbet_pkg::cmd_t             cmd,
    input  logic [COORD_WIDTH-1:0]     pixel_x,
    input  logic [COORD_WIDTH-1:0]     pixel_y,
    input  logic [mbet_pkg::REG_W-1:0] image_width,
    input  logic [mbet_pkg::REG_W-1:0] image_height,
    output mbet_pkg::status_t          status
);

    localparam int DW = COORD_WIDTH + mbet_pkg::FRAC_BITS;

    logic [DW-1:0] quo_x;
    logic [DW-1:0] quo_y;

    logic signed [mbet_pkg::Q_W-1:0]    cr_reg;
    logic signed [mbet_pkg::Q_W-1:0]    ci_reg;
    logic signed [mbet_pkg::Q_W-1:0]    zr_reg;
    logic signed [mbet_pkg::Q_W-1:0]    zi_reg;
    logic        [mbet_pkg::PROD_W-1:0] rr_reg;
    logic        [mbet_pkg::PROD_W-1:0] ii_reg;
    logic signed [mbet_pkg::PROD_W-1:0] ri_reg;
    logic signed [mbet_pkg::PROD_W-1:0] diff_reg;

    logic signed [mbet_pkg::Q_W-1:0]    mul_a;
    logic signed [mbet_pkg::Q_W-1:0]    mul_b;
    logic signed [mbet_pkg::PROD_W-1:0] prod;
    logic        [mbet_pkg::PROD_W-1:0] mag_sum;
    logic signed [mbet_pkg::UPD_W-1:0]  nr;
    logic signed [mbet_pkg::UPD_W-1:0]  ni;

    // q minus offset, clipped at the top of q4.28; q is never negative
    function automatic logic [mbet_pkg::Q_W-1:0] map_sat(
        input logic [DW-1:0]            q,
        input logic [mbet_pkg::Q_W-1:0] off
    );
        logic [DW:0] lim;
        lim = (DW+1)'(33'h0_8000_0000) + (DW+1)'(off);
        if ({1'b0, q} >= lim)
        begin
            return mbet_pkg::Q_MAX;
        end
        else
        begin
            return q[mbet_pkg::Q_W-1:0] - off;
        end
    endfunction

    mbet_divider #(
        .DIVIDEND_W (DW)
    ) u_div_x (
        .clk      (clk),
        .start    (cmd.load),
        .step     (cmd.div_step),
        .dividend ({pixel_x, {mbet_pkg::FRAC_BITS{1'b0}}}),
        .divisor  (image_width),
        .quotient (quo_x)
    );

    mbet_divider #(
        .DIVIDEND_W (DW)
    ) u_div_y (
        .clk      (clk),
        .start    (cmd.load),
        .step     (cmd.div_step),
        .dividend ({pixel_y, {mbet_pkg::FRAC_BITS{1'b0}}}),
        .divisor  (image_height),
        .quotient (quo_y)
    );

    // one shared multiplier
    always_comb
    begin
        case (cmd.mul_sel)
            mbet_pkg::MUL_RR:
            begin
                mul_a = zr_reg;
                mul_b = zr_reg;
            end
            mbet_pkg::MUL_II:
            begin
                mul_a = zi_reg;
                mul_b = zi_reg;
            end
            mbet_pkg::MUL_RI:
            begin
                mul_a = zr_reg;
                mul_b = zi_reg;
            end
            default:
            begin
                mul_a = zr_reg;
                mul_b = zr_reg;
            end
        endcase
    end

    assign prod = mbet_pkg::PROD_W'(mul_a) * mbet_pkg::PROD_W'(mul_b);

    assign mag_sum        = rr_reg + ii_reg;
    assign status.escaped = (mag_sum >= mbet_pkg::ESCAPE_Q56);

    assign nr = mbet_pkg::UPD_W'(diff_reg >>> mbet_pkg::FRAC_BITS) + mbet_pkg::UPD_W'(cr_reg);
    assign ni = mbet_pkg::UPD_W'(ri_reg >>> (mbet_pkg::FRAC_BITS - 1))
              + mbet_pkg::UPD_W'(ci_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.map)
        begin
            cr_reg <= map_sat(quo_x, mbet_pkg::THREE_HALF_Q);
            ci_reg <= map_sat(quo_y, mbet_pkg::ONE_HALF_Q);
            zr_reg <= '0;
            zi_reg <= '0;
        end
        else if (cmd.z_update)
        begin
            zr_reg <= mbet_pkg::sat_q(nr);
            zi_reg <= mbet_pkg::sat_q(ni);
        end
        if (cmd.mul_en)
        begin
            case (cmd.mul_sel)
                mbet_pkg::MUL_RR:
                begin
                    rr_reg <= prod;
                end
                mbet_pkg::MUL_II:
                begin
                    ii_reg <= prod;
                end
                mbet_pkg::MUL_RI:
                begin
                    ri_reg   <= prod;
                    diff_reg <= $signed(rr_reg) - $signed(ii_reg);
                end
                default:
                begin
                    rr_reg <= prod;
                end
            endcase
        end
    end

endmodule

// File: src/mbet_ctrl.sv
module mbet_ctrl #(
    parameter int MAX_ITER    = mbet_pkg::MAX_ITER_DEF,
    parameter int COORD_WIDTH = mbet_pkg::COORD_WIDTH_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [mbet_pkg::COUNT_W-1:0] escape_count,
    output mbet_pkg::cmd_t               cmd,
    input  mbet_pkg::status_t            status
);

    localparam int DIV_STEPS = COORD_WIDTH + mbet_pkg::FRAC_BITS;
    localparam int CNT_W     = $clog2(DIV_STEPS);
    localparam int ITER_W    = $clog2(MAX_ITER + 1);

    localparam logic [CNT_W-1:0]  DIV_LAST  = CNT_W'(DIV_STEPS - 1);
    localparam logic [ITER_W-1:0] ITER_LAST = ITER_W'(MAX_ITER);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_MAP,
        S_SQR_R,
        S_SQR_I,
        S_CROSS,
        S_UPDATE,
        S_DONE
    } state_t;

    state_t                        state_reg;
    state_t                        state_next;
    logic [CNT_W-1:0]              div_cnt_reg;
    logic [CNT_W-1:0]              div_cnt_next;
    logic [ITER_W-1:0]             iter_reg;
    logic [ITER_W-1:0]             iter_next;
    logic                          out_valid_reg;
    logic                          out_valid_next;
    logic [mbet_pkg::COUNT_W-1:0]  count_reg;
    logic [mbet_pkg::COUNT_W-1:0]  count_next;
    logic [ITER_W+mbet_pkg::COUNT_W-1:0] iter_ext;

    assign iter_ext = {{mbet_pkg::COUNT_W{1'b0}}, iter_reg};

    always_comb
    begin
        state_next     = state_reg;
        div_cnt_next   = div_cnt_reg;
        iter_next      = iter_reg;
        out_valid_next = out_valid_reg;
        count_next     = count_reg;
        cmd            = '{load: 1'b0, div_step: 1'b0, map: 1'b0, mul_en: 1'b0,
                           mul_sel: mbet_pkg::MUL_RR, z_update: 1'b0};

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load     = 1'b1;
                    div_cnt_next = '0;
                    state_next   = S_DIV;
                end
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                div_cnt_next = div_cnt_reg + 1'b1;
                if (div_cnt_reg == DIV_LAST)
                begin
                    state_next = S_MAP;
                end
            end
            S_MAP:
            begin
                cmd.map    = 1'b1;
                iter_next  = '0;
                state_next = S_SQR_R;
            end
            S_SQR_R:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = mbet_pkg::MUL_RR;
                state_next  = S_SQR_I;
            end
            S_SQR_I:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = mbet_pkg::MUL_II;
                state_next  = S_CROSS;
            end
            S_CROSS:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = mbet_pkg::MUL_RI;
                if (status.escaped || (iter_reg >= ITER_LAST))
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_UPDATE;
                end
            end
            S_UPDATE:
            begin
                cmd.z_update = 1'b1;
                iter_next    = iter_reg + 1'b1;
                state_next   = S_SQR_R;
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    count_next     = (iter_reg < ITER_LAST) ? iter_ext[mbet_pkg::COUNT_W-1:0]
                                                            : '0;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            div_cnt_reg   <= '0;
            iter_reg      <= '0;
            out_valid_reg <= 1'b0;
            count_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            div_cnt_reg   <= div_cnt_next;
            iter_reg      <= iter_next;
            out_valid_reg <= out_valid_next;
            count_reg     <= count_next;
        end
    end

    assign in_ready     = (state_reg == S_IDLE);
    assign out_valid    = out_valid_reg;
    assign escape_count = count_reg;

endmodule

// File: src/mandelbrot_escape_time.sv
// channel  | handshake               | payload
// ---------+-------------------------+---------------------------------
// in       | in_valid / in_ready     | pixel_x, pixel_y
// out      | out_valid / out_ready   | escape_count
// cfg      | cfg_write               | cfg_index, cfg_data
//
// one item at a time: after an accept the block runs a bit-serial divide, maps the
// quotients to c and then repeats the step, at most MAX_ITER z updates in all; the
// shared 32x32 multiplier forms three products per step (zr*zr, zi*zi and zr*zi)
// before the escape test and the z update
// reset sets image_width to 800 and image_height to 600
// a result waits in the output register while the next item is taken
module mandelbrot_escape_time #(
    parameter int MAX_ITER    = mbet_pkg::MAX_ITER_DEF,
    parameter int COORD_WIDTH = mbet_pkg::COORD_WIDTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [COORD_WIDTH-1:0]         pixel_x,
    input  logic [COORD_WIDTH-1:0]         pixel_y,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [mbet_pkg::COUNT_W-1:0]   escape_count,
    input  logic                           cfg_write,
    input  logic [mbet_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [mbet_pkg::REG_W-1:0]     cfg_data
);

    logic [mbet_pkg::REG_W-1:0] width_reg;
    logic [mbet_pkg::REG_W-1:0] height_reg;
    mbet_pkg::cmd_t             cmd;
    mbet_pkg::status_t          status;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= mbet_pkg::WIDTH_RESET;
            height_reg <= mbet_pkg::HEIGHT_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                mbet_pkg::CFG_IMAGE_WIDTH:
                begin
                    width_reg <= cfg_data;
                end
                mbet_pkg::CFG_IMAGE_HEIGHT:
                begin
                    height_reg <= cfg_data;
                end
                default:
                begin
                    width_reg <= width_reg;
                end
            endcase
        end
    end

    mbet_ctrl #(
        .MAX_ITER    (MAX_ITER),
        .COORD_WIDTH (COORD_WIDTH)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .escape_count (escape_count),
        .cmd          (cmd),
        .status       (status)
    );

    mbet_datapath #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_datapath (
        .clk          (clk),
        .cmd          (cmd),
        .pixel_x      (pixel_x),
        .pixel_y      (pixel_y),
        .image_width  (width_reg),
        .image_height (height_reg),
        .status       (status)
    );

endmodule

// File: src/mbet_checker.sv
module mbet_checker #(
    parameter int MAX_ITER = mbet_pkg::MAX_ITER_DEF
) (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         in_valid,
    input logic                         in_ready,
    input logic                         out_valid,
    input logic                         out_ready,
    input logic [mbet_pkg::COUNT_W-1:0] escape_count
);

    // a waiting result holds its value
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(escape_count))
    else $error("result changed while stalled");

    // one item in flight: busy right after an accept
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
    else $error("input taken again while busy");

    // a fresh result frees the input side at once
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> in_ready)
    else $error("result posted while still busy");

    // a posted count stays below MAX_ITER, as a count at the limit reads as zero
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (int'(escape_count) < MAX_ITER) || (MAX_ITER > 64))
    else $error("escape count out of range");

endmodule

bind mandelbrot_escape_time mbet_checker #(
    .MAX_ITER (MAX_ITER)
) u_mbet_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .escape_count (escape_count)
);
